[rtl/core/pwfd_pkg.sv]
// Shared types, codes and window helper for the pulse width frame decoder.
// No dependencies; every other file in rtl/core imports this package.
package pwfd_pkg;

  localparam int WIDTH_W          = 16;
  localparam int FRAME_W          = 32;
  localparam int STATUS_W         = 2;
  localparam int SYM_W            = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int SYMBOLS_PER_BYTE = 4;
  localparam int SYMBOL_MAX       = 3;
  localparam int FRAME_BYTES_DEF  = 4;

  typedef logic [WIDTH_W-1:0]   width_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [SYM_W-1:0]     sym_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Result status codes
  localparam status_t ST_NONE  = 2'd0;
  localparam status_t ST_SYNC  = 2'd1;
  localparam status_t ST_FRAME = 2'd2;
  localparam status_t ST_ERROR = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t CFG_SYMBOL_BASE = 2'd0;
  localparam cfg_idx_t CFG_SYMBOL_TOL  = 2'd1;
  localparam cfg_idx_t CFG_SYNC_WIDTH  = 2'd2;
  localparam cfg_idx_t CFG_SYNC_TOL    = 2'd3;

  // Configuration reset values
  localparam width_t SYMBOL_BASE_RST = 16'd100;
  localparam width_t SYMBOL_TOL_RST  = 16'd25;
  localparam width_t SYNC_WIDTH_RST  = 16'd1000;
  localparam width_t SYNC_TOL_RST    = 16'd100;

  typedef struct packed {
    width_t symbol_base;
    width_t symbol_tol;
    width_t sync_width;
    width_t sync_tol;
  } cfg_t;

  typedef struct packed {
    logic sync_hit;
    logic sym_hit;
    sym_t sym;
  } match_t;

  // Low bound clamps at zero, high bound wraps at 16 bits
  function automatic logic in_window(width_t w, width_t target, width_t tol);
    width_t lo;
    width_t hi;
    lo = (target > tol) ? width_t'(target - tol) : '0;
    hi = width_t'(target + tol);
    return (w >= lo) && (w <= hi);
  endfunction

endpackage

[rtl/core/pwfd_ifs.sv]
// Valid/ready channel interfaces for the pulse width frame decoder.
// Depends on pwfd_pkg for payload types.
interface pwfd_in_if;
  import pwfd_pkg::*;
  logic   valid;
  logic   ready;
  width_t pulse_width_us;
  modport source(output valid, output pulse_width_us, input ready);
  modport sink(input valid, input pulse_width_us, output ready);
endinterface

interface pwfd_out_if;
  import pwfd_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  frame_t  frame_data;
  modport source(output valid, output status, output frame_data, input ready);
  modport sink(input valid, input status, input frame_data, output ready);
endinterface

[rtl/core/pwfd_match.sv]
// Window matcher: sync window and the four symbol windows, first symbol wins.
// Depends on pwfd_pkg (cfg_t, match_t, in_window).
module pwfd_match (
  input  pwfd_pkg::width_t width_us,
  input  pwfd_pkg::cfg_t   cfg,
  output pwfd_pkg::match_t match
);
  import pwfd_pkg::*;

  width_t target [SYMBOL_MAX+1];
  logic   hit    [SYMBOL_MAX+1];

  // Symbol targets (k+1)*base, wrapped at 16 bits
  assign target[0] = cfg.symbol_base;
  assign target[1] = width_t'(cfg.symbol_base << 1);
  assign target[2] = width_t'(cfg.symbol_base + width_t'(cfg.symbol_base << 1));
  assign target[3] = width_t'(cfg.symbol_base << 2);

  always_comb begin
    for (int k = 0; k <= SYMBOL_MAX; k++) begin
      hit[k] = in_window(width_us, target[k], cfg.symbol_tol);
    end
  end

  // Lowest matching symbol takes priority
  always_comb begin
    match.sync_hit = in_window(width_us, cfg.sync_width, cfg.sync_tol);
    match.sym_hit  = 1'b0;
    match.sym      = '0;
    for (int k = SYMBOL_MAX; k >= 0; k--) begin
      if (hit[k]) begin
        match.sym_hit = 1'b1;
        match.sym     = sym_t'(k);
      end
    end
  end

endmodule

[rtl/core/pulse_width_frame_decoder.sv]
// Top level of the pulse width frame decoder: config registers, frame state, output buffer.
// Depends on pwfd_pkg, pwfd_ifs (pwfd_in_if, pwfd_out_if) and pwfd_match.
//
//   port      dir   beat contents
//   in_ch     sink  pulse_width_us (16 bits)
//   out_ch    src   status (2 bits), frame_data (32 bits)
//   cfg_*     in    cfg_we, cfg_index (2 bits), cfg_wdata (16 bits), no read-back
//
// One beat per cycle while in_ch.ready is high: a pulse width is matched and the frame state
// updated in the cycle it is taken; its result is registered in the output or skid register.
// Every input beat yields exactly one output beat.
// A skid register behind the output register lets one more beat in while out_ch
// stalls; in_ch.ready is low only while the skid register is full.
// Synchronous active-low reset restores the register defaults and disarms the decoder.
module pulse_width_frame_decoder #(
  parameter int FRAME_BYTES = pwfd_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  pwfd_in_if.sink            in_ch,
  pwfd_out_if.source         out_ch,
  input  logic               cfg_we,
  input  pwfd_pkg::cfg_idx_t cfg_index,
  input  pwfd_pkg::width_t   cfg_wdata
);
  import pwfd_pkg::*;

  localparam int FRAME_SYMBOLS = SYMBOLS_PER_BYTE * FRAME_BYTES;
  localparam int CNT_W         = $clog2(FRAME_SYMBOLS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_SYMBOLS - 1);

  cfg_t             cfg_r;
  logic             armed_r,  armed_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  frame_t           accum_r,  accum_nxt;
  status_t          res_status;
  frame_t           res_data;
  frame_t           accum_or;
  match_t           match;
  logic             accept;

  logic    out_valid_r,  out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  frame_t  out_data_r,   out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  status_t skid_status_r, skid_status_nxt;
  frame_t  skid_data_r,  skid_data_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_base <= SYMBOL_BASE_RST;
      cfg_r.symbol_tol  <= SYMBOL_TOL_RST;
      cfg_r.sync_width  <= SYNC_WIDTH_RST;
      cfg_r.sync_tol    <= SYNC_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYMBOL_BASE: cfg_r.symbol_base <= cfg_wdata;
        CFG_SYMBOL_TOL:  cfg_r.symbol_tol  <= cfg_wdata;
        CFG_SYNC_WIDTH:  cfg_r.sync_width  <= cfg_wdata;
        CFG_SYNC_TOL:    cfg_r.sync_tol    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pwfd_match u_match (
    .width_us (in_ch.pulse_width_us),
    .cfg      (cfg_r),
    .match    (match)
  );

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !skid_valid_r;

  // Place the symbol at bits 2i+1:2i; past bit 31 the shift drops it
  assign accum_or = accum_r | (FRAME_W'(match.sym) << {count_r, 1'b0});

  // Frame state update and result for the beat taken this cycle
  always_comb begin
    armed_nxt  = armed_r;
    count_nxt  = count_r;
    accum_nxt  = accum_r;
    res_status = ST_NONE;
    res_data   = '0;
    if (accept) begin
      if (match.sync_hit) begin
        armed_nxt  = 1'b1;
        count_nxt  = '0;
        accum_nxt  = '0;
        res_status = ST_SYNC;
      end else if (armed_r) begin
        if (!match.sym_hit) begin
          armed_nxt  = 1'b0;
          count_nxt  = '0;
          res_status = ST_ERROR;
        end else begin
          accum_nxt = accum_or;
          if (count_r == CNT_LAST) begin
            armed_nxt  = 1'b0;
            count_nxt  = '0;
            res_status = ST_FRAME;
            res_data   = accum_or;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
    end
  end

  // Output register with skid: refill from skid first, park new beat on stall
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_data_nxt    = out_data_r;
    skid_valid_nxt  = skid_valid_r;
    skid_status_nxt = skid_status_r;
    skid_data_nxt   = skid_data_r;
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = skid_status_r;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status;
        out_data_nxt   = res_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      skid_valid_nxt  = 1'b1;
      skid_status_nxt = res_status;
      skid_data_nxt   = res_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      count_r      <= '0;
      accum_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      armed_r      <= armed_nxt;
      count_r      <= count_nxt;
      accum_r      <= accum_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload holds
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    skid_status_r <= skid_status_nxt;
    skid_data_r   <= skid_data_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.frame_data = out_data_r;

endmodule

[tb/sv/tb_pulse_width_frame_decoder.sv]
// Self-checking bench for pulse_width_frame_decoder: valid/ready stimulus, config writes
// and a cycle-free decode predictor compared beat by beat on the result channel.
// Depends on pwfd_pkg, pwfd_ifs and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwfd_pkg::*;

  localparam int FRAME_BYTES  = FRAME_BYTES_DEF;
  localparam int FRAME_SYMS   = SYMBOLS_PER_BYTE * FRAME_BYTES;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 244;
  localparam int IDLE_LIMIT   = 1000;
  localparam int GAP_MAX      = 13;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    status_t status;
    frame_t  frame;
  } result_t;

  typedef struct packed {
    width_t  w;
    logic    fixed;
    status_t st;
    frame_t  fr;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  width_t cfg_wdata;

  pwfd_in_if  in_ch();
  pwfd_out_if out_ch();

  pulse_width_frame_decoder #(.FRAME_BYTES(FRAME_BYTES)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Decoder state mirrored by the predictor
  cfg_t    cfg_model = '{SYMBOL_BASE_RST, SYMBOL_TOL_RST, SYNC_WIDTH_RST, SYNC_TOL_RST};
  logic    armed_q   = 1'b0;
  int      sym_cnt   = 0;
  frame_t  frame_acc = '0;

  result_t frame_q[$];
  int      items_sent     = 0;
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  bit      in_quiet       = 1'b0;
  bit      out_quiet      = 1'b0;

  // Directed stimulus at reset configuration; fixed rows carry their result
  row_t dir_rows[25] = '{
    '{16'd0,     1'b1, ST_NONE,  32'h0},  // zero width, disarmed
    '{16'd65535, 1'b1, ST_NONE,  32'h0},  // full scale, disarmed
    '{16'd100,   1'b1, ST_NONE,  32'h0},  // symbol width while disarmed
    '{16'd900,   1'b1, ST_SYNC,  32'h0},  // low edge of sync window
    '{16'd75,    1'b0, ST_NONE,  32'h0},  // low edge of symbol 0
    '{16'd425,   1'b0, ST_NONE,  32'h0},  // high edge of symbol 3
    '{16'd1000,  1'b1, ST_SYNC,  32'h0},  // resync while armed
    '{16'd126,   1'b1, ST_ERROR, 32'h0},  // gap between symbol windows
    '{16'd1100,  1'b1, ST_SYNC,  32'h0},  // high edge of sync window
    '{16'd75,    1'b0, ST_NONE,  32'h0},
    '{16'd125,   1'b0, ST_NONE,  32'h0},
    '{16'd175,   1'b0, ST_NONE,  32'h0},
    '{16'd225,   1'b0, ST_NONE,  32'h0},
    '{16'd275,   1'b0, ST_NONE,  32'h0},
    '{16'd325,   1'b0, ST_NONE,  32'h0},
    '{16'd375,   1'b0, ST_NONE,  32'h0},
    '{16'd425,   1'b0, ST_NONE,  32'h0},
    '{16'd100,   1'b0, ST_NONE,  32'h0},
    '{16'd200,   1'b0, ST_NONE,  32'h0},
    '{16'd300,   1'b0, ST_NONE,  32'h0},
    '{16'd400,   1'b0, ST_NONE,  32'h0},
    '{16'd100,   1'b0, ST_NONE,  32'h0},
    '{16'd400,   1'b0, ST_NONE,  32'h0},
    '{16'd200,   1'b0, ST_NONE,  32'h0},
    '{16'd300,   1'b0, ST_NONE,  32'h0}   // sixteenth symbol completes the frame
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Window test: floor clamps at zero, ceiling keeps only the low 16 bits of the sum
  function automatic bit width_hits(width_t w, width_t center, width_t spread);
    logic [16:0] ceil_sum;
    width_t floor_v;
    floor_v  = (center > spread) ? width_t'(center - spread) : width_t'(0);
    ceil_sum = {1'b0, center} + {1'b0, spread};
    return (w >= floor_v) && (w <= ceil_sum[15:0]);
  endfunction

  // Advance the mirrored decoder by one pulse and return its result
  function automatic result_t decode_pulse(width_t w);
    result_t r;
    bit      found;
    sym_t    sym;
    width_t  center;
    r     = '0;
    found = 1'b0;
    sym   = '0;
    if (width_hits(w, cfg_model.sync_width, cfg_model.sync_tol)) begin
      frame_acc = '0;
      sym_cnt   = 0;
      armed_q   = 1'b1;
      r.status  = ST_SYNC;
    end else if (armed_q) begin
      for (int k = 0; k <= SYMBOL_MAX; k++) begin
        center = width_t'((k + 1) * cfg_model.symbol_base);
        if (!found && width_hits(w, center, cfg_model.symbol_tol)) begin
          sym   = sym_t'(k);
          found = 1'b1;
        end
      end
      if (!found) begin
        armed_q  = 1'b0;
        sym_cnt  = 0;
        r.status = ST_ERROR;
      end else begin
        if (sym_cnt * 2 < FRAME_W) frame_acc = frame_acc | (frame_t'(sym) << (sym_cnt * 2));
        sym_cnt++;
        if (sym_cnt >= FRAME_SYMS) begin
          armed_q  = 1'b0;
          sym_cnt  = 0;
          r.status = ST_FRAME;
          r.frame  = frame_acc;
        end
      end
    end
    return r;
  endfunction

  // Pick a width inside a window (mode 0), on its floor (1), its ceiling (2) or just outside
  function automatic width_t near_window(width_t center, width_t spread, int mode);
    width_t floor_v;
    width_t ceil_v;
    floor_v = (center > spread) ? width_t'(center - spread) : width_t'(0);
    ceil_v  = width_t'(center + spread);
    case (mode)
      0: begin
        if (floor_v <= ceil_v) return width_t'($urandom_range(ceil_v, floor_v));
        return width_t'($urandom);
      end
      1: return floor_v;
      2: return ceil_v;
      default: return $urandom_range(0, 1) ? width_t'(floor_v - 1'b1) : width_t'(ceil_v + 1'b1);
    endcase
  endfunction

  function automatic int window_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 7) return 1;
    if (r == 8) return 2;
    return 0;
  endfunction

  function automatic cfg_t phase_cfg(int p);
    cfg_t c;
    case (p)
      0: c = '{16'd1000, 16'd0, 16'd0, 16'd0};
      1: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      2: c = '{16'd20000, 16'd6000, 16'd5000, 16'd100};
      3: c = '{16'd0, 16'd0, 16'd300, 16'd50};
      4: c = '{16'd100, 16'd200, 16'hFFFF, 16'd0};
      5: begin
        c.symbol_base = width_t'($urandom_range(1, 16000));
        c.symbol_tol  = width_t'($urandom_range(0, c.symbol_base / 2));
        c.sync_width  = width_t'($urandom);
        c.sync_tol    = width_t'($urandom_range(0, 3000));
      end
      6: c = cfg_t'({$urandom, $urandom});
      default: c = '{SYMBOL_BASE_RST, SYMBOL_TOL_RST, SYNC_WIDTH_RST, SYNC_TOL_RST};
    endcase
    return c;
  endfunction

  // Offer one pulse beat, wait for the handshake and record its result; ends at a falling edge
  task automatic send_pulse(width_t w, bit fixed, result_t fixed_res);
    int gap;
    result_t pred;
    gap = in_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pulse_width_us <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = decode_pulse(w);
    frame_q.push_back(fixed ? fixed_res : pred);
    items_sent++;
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    @(negedge clk);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 3) == 0)
      send_pulse(near_window(cfg_model.sync_width, cfg_model.sync_tol, 3), 1'b0, '0);
    else
      send_pulse(width_t'($urandom), 1'b0, '0);
  endtask

  // Sync followed by symbols; a few frames are cut short, run long or take a stray pulse
  task automatic send_frame();
    int nsym;
    int k;
    send_pulse(near_window(cfg_model.sync_width, cfg_model.sync_tol, window_mode()), 1'b0, '0);
    nsym = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : FRAME_SYMS;
    for (int i = 0; i < nsym; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_noise();
      end else begin
        k = $urandom_range(0, SYMBOL_MAX);
        send_pulse(near_window(width_t'((k + 1) * cfg_model.symbol_base),
                               cfg_model.symbol_tol, window_mode()), 1'b0, '0);
      end
    end
  endtask

  // Drop valid and hold until every result is back; called at a falling edge
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_cfg(cfg_t c);
    width_t vals[4];
    vals = '{c.symbol_base, c.symbol_tol, c.sync_width, c.sync_tol};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we    <= 1'b0;
    cfg_model = c;
    @(negedge clk);
  endtask

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t mismatch (%s): expected status %0d frame %08h, got status %0d frame %08h",
               $realtime, what, want.status, want.frame, got.status, got.frame);
  endfunction

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      got.status = out_ch.status;
      got.frame  = out_ch.frame_data;
      if (frame_q.size() == 0) begin
        note_mismatch("no beat pending", '0, got);
      end else begin
        want = frame_q.pop_front();
        if (got.status !== want.status) note_mismatch("status", want, got);
        else if (got.frame !== want.frame) note_mismatch("frame_data", want, got);
      end
    end
  end

  // Stall the result channel a random number of cycles before each beat
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid === 1'b1)) @(posedge clk);
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid === 1'b1 && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int start;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_SYMBOL_BASE;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.pulse_width_us = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows at the reset configuration
    foreach (dir_rows[i])
      send_pulse(dir_rows[i].w, dir_rows[i].fixed, result_t'({dir_rows[i].st, dir_rows[i].fr}));

    // Random frames and noise under each configuration
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_cfg(phase_cfg(p));
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) send_frame();
        else send_noise();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && frame_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[pulse_width_frame_decoder.f]
rtl/core/pwfd_pkg.sv
rtl/core/pwfd_ifs.sv
rtl/core/pwfd_match.sv
rtl/core/pulse_width_frame_decoder.sv
tb/sv/tb_pulse_width_frame_decoder.sv
